FILE: design/echp_pkg.sv
// Package: payload types and pipeline word types for the halo pixel unit
`timescale 1ns / 1ps
`default_nettype none
package echp_pkg;

   localparam int unsigned MAX_DIM_DEF   = 1024;
   localparam int unsigned TAB_DEPTH_DEF = 1024;
   localparam int unsigned DIV_STEPS     = 32;
   localparam int unsigned SQRT_STEPS    = 17;

   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_FILL   = 2'd2,
      CSR_BASE   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [9:0] column;
      logic [9:0] row;
   } req_type;

   typedef struct packed {
      logic       inside_res;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   typedef struct packed {
      logic        vld;
      logic        ins;
      logic        eq;
      logic [40:0] s2;
      logic [40:0] rem;
      logic [32:0] q;
   } div_word_type;

   typedef struct packed {
      logic        vld;
      logic        ins;
      logic [32:0] v;
      logic [33:0] res;
   } sqrt_word_type;

endpackage
`default_nettype wire

FILE: design/echp_div_cell.sv
// One restoring division step: shifts the remainder and takes one quotient bit
`timescale 1ns / 1ps
`default_nettype none
module echp_div_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire echp_pkg::div_word_type word_i,
   output      echp_pkg::div_word_type word_o
);
   echp_pkg::div_word_type word_ff, word_in;
   logic [41:0] r2;

   always_comb begin
      word_in = word_i;
      r2      = {word_i.rem, 1'b0};
      word_in.q = {word_i.q[31:0], 1'b0};
      if (r2 >= {1'b0, word_i.s2}) begin
         r2 = r2 - {1'b0, word_i.s2};
         word_in.q[0] = 1'b1;
      end
      word_in.rem = r2[40:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.vld <= 1'b0;
      end else begin
         word_ff.vld <= word_in.vld;
      end
      word_ff.ins <= word_in.ins;
      word_ff.eq  <= word_in.eq;
      word_ff.s2  <= word_in.s2;
      word_ff.rem <= word_in.rem;
      word_ff.q   <= word_in.q;
   end

   assign word_o = word_ff;
endmodule
`default_nettype wire

FILE: design/echp_sqrt_cell.sv
// One digit of the bitwise integer square root, for a fixed trial bit
`timescale 1ns / 1ps
`default_nettype none
module echp_sqrt_cell #(
   parameter int unsigned SHIFT = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire echp_pkg::sqrt_word_type word_i,
   output      echp_pkg::sqrt_word_type word_o
);
   localparam logic [33:0] BIT = 34'd1 << SHIFT;

   echp_pkg::sqrt_word_type word_ff, word_in;
   logic [33:0] trial;

   always_comb begin
      word_in = word_i;
      trial   = word_i.res + BIT;
      if ({1'b0, word_i.v} >= trial) begin
         word_in.v   = word_i.v - trial[32:0];
         word_in.res = (word_i.res >> 1) + BIT;
      end else begin
         word_in.res = word_i.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.vld <= 1'b0;
      end else begin
         word_ff.vld <= word_in.vld;
      end
      word_ff.ins <= word_in.ins;
      word_ff.v   <= word_in.v;
      word_ff.res <= word_in.res;
   end

   assign word_o = word_ff;
endmodule
`default_nettype wire

FILE: design/elliptic_cosine_halo_pixel_unit.sv
// Top level: elliptic cosine halo pixel shader, one pixel a clock through a chain of cells
//
//   channel  ports                                 word
//   req      start, busy, req_data                 column, row
//   rsp      rsp_valid, rsp_data                   inside_res, red, green, blue
//   csr      csr_we, csr_index, csr_wdata          width, height, fill, base
//
// A pixel is taken every cycle; busy stays low and the receiver cannot stall.
// The pipeline has 3 offset and product stages, 32 division cells,
// 17 square root cells and 4 stages for index, lookup, shading and output.
// Reset clears the valid chain and loads the register defaults. The result
// shows for one cycle with rsp_valid.
`timescale 1ns / 1ps
`default_nettype none
module elliptic_cosine_halo_pixel_unit #(
   parameter int unsigned WEIGHT_TABLE_DEPTH = echp_pkg::TAB_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output      logic              busy,
   input  wire echp_pkg::req_type req_data,
   output      logic              rsp_valid,
   output      echp_pkg::rsp_type rsp_data,
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [23:0]       csr_wdata
);
   localparam int unsigned KW  = $clog2(WEIGHT_TABLE_DEPTH + 1);
   localparam int unsigned DW  = $clog2(WEIGHT_TABLE_DEPTH + 1) + 1;
   localparam int unsigned LAT = 56;

   // (1 + cos(3.14*k/depth)) / 2 in Q1.15, Taylor series in Q28
   wire [15:0] wtab [WEIGHT_TABLE_DEPTH + 1];

   for (genvar i = 0; i <= int'(WEIGHT_TABLE_DEPTH); i++) begin : g_wtab
      localparam longint unsigned X  =
         ((64'(i) * 64'd314) << 28) / (64'd100 * 64'(WEIGHT_TABLE_DEPTH));
      localparam longint unsigned X2  = (X * X) >> 28;
      localparam longint unsigned T0  = 64'd1 << 28;
      localparam longint unsigned T1  = ((T0 * X2) >> 28) / 64'd2;
      localparam longint unsigned T2  = ((T1 * X2) >> 28) / 64'd12;
      localparam longint unsigned T3  = ((T2 * X2) >> 28) / 64'd30;
      localparam longint unsigned T4  = ((T3 * X2) >> 28) / 64'd56;
      localparam longint unsigned T5  = ((T4 * X2) >> 28) / 64'd90;
      localparam longint unsigned T6  = ((T5 * X2) >> 28) / 64'd132;
      localparam longint unsigned T7  = ((T6 * X2) >> 28) / 64'd182;
      localparam longint unsigned T8  = ((T7 * X2) >> 28) / 64'd240;
      localparam longint unsigned T9  = ((T8 * X2) >> 28) / 64'd306;
      localparam longint unsigned T10 = ((T9 * X2) >> 28) / 64'd380;
      localparam longint unsigned T11 = ((T10 * X2) >> 28) / 64'd462;
      localparam longint unsigned T12 = ((T11 * X2) >> 28) / 64'd552;
      localparam longint unsigned T13 = ((T12 * X2) >> 28) / 64'd650;
      localparam longint unsigned T14 = ((T13 * X2) >> 28) / 64'd756;
      localparam longint unsigned POS =
         (64'd1 << 28) + T0 + T2 + T4 + T6 + T8 + T10 + T12 + T14;
      localparam longint unsigned NEG = T1 + T3 + T5 + T7 + T9 + T11 + T13;
      localparam longint unsigned SUM = (POS > NEG) ? POS - NEG : 64'd0;
      localparam longint unsigned WR  = (SUM + (64'd1 << 13)) >> 14;
      localparam longint unsigned WT  = (WR > 64'd32768) ? 64'd32768 : WR;
      assign wtab[i] = 16'(WT);
   end

   // registers
   logic [10:0] width_ff, height_ff;
   logic [23:0] fill_ff, base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd64;
         height_ff <= 11'd32;
         fill_ff   <= 24'd0;
         base_ff   <= 24'd0;
      end else if (csr_we) begin
         unique case (echp_pkg::csr_index_type'(csr_index))
            echp_pkg::CSR_WIDTH:  width_ff  <= csr_wdata[10:0];
            echp_pkg::CSR_HEIGHT: height_ff <= csr_wdata[10:0];
            echp_pkg::CSR_FILL:   fill_ff   <= csr_wdata;
            echp_pkg::CSR_BASE:   base_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // front: offsets
   logic        v1_ff, i1_ff;
   logic [9:0]  dx_ff, dy_ff, cx_ff, cy_ff;
   logic [9:0]  cx_in, cy_in, dx_in, dy_in;
   logic        i1_in;

   always_comb begin
      cx_in = width_ff[10:1];
      cy_in = height_ff[10:1];
      dx_in = (req_data.column >= cx_in) ? req_data.column - cx_in : cx_in - req_data.column;
      dy_in = (req_data.row >= cy_in) ? req_data.row - cy_in : cy_in - req_data.row;
      i1_in = !(width_ff < 11'd2 || height_ff < 11'd2 ||
                {1'b0, req_data.column} >= width_ff || {1'b0, req_data.row} >= height_ff);
   end

   logic        v2_ff, i2_ff;
   logic [19:0] pa_ff, pb_ff, ss_ff;
   logic        v3_ff, i3_ff;
   logic [39:0] pa2_ff, pb2_ff, s2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      i1_ff  <= i1_in;
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      cx_ff  <= cx_in;
      cy_ff  <= cy_in;
      i2_ff  <= i1_ff;
      pa_ff  <= dx_ff * cy_ff;
      pb_ff  <= dy_ff * cx_ff;
      ss_ff  <= cx_ff * cy_ff;
      i3_ff  <= i2_ff;
      pa2_ff <= pa_ff * pa_ff;
      pb2_ff <= pb_ff * pb_ff;
      s2_ff  <= ss_ff * ss_ff;
   end

   // division chain: q = D * 2^32 / s^2
   echp_pkg::div_word_type div_w [echp_pkg::DIV_STEPS + 1];
   logic [40:0] dd;

   always_comb begin
      dd = {1'b0, pa2_ff} + {1'b0, pb2_ff};
      div_w[0].vld = v3_ff;
      div_w[0].ins = i3_ff && (dd <= {1'b0, s2_ff});
      div_w[0].eq  = (dd == {1'b0, s2_ff});
      div_w[0].s2  = {1'b0, s2_ff};
      div_w[0].rem = dd;
      div_w[0].q   = 33'd0;
   end

   for (genvar g = 0; g < int'(echp_pkg::DIV_STEPS); g++) begin : g_div
      echp_div_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .word_i (div_w[g]),
         .word_o (div_w[g + 1])
      );
   end

   // square root chain
   echp_pkg::sqrt_word_type sq_w [echp_pkg::SQRT_STEPS + 1];
   always_comb begin
      sq_w[0].vld = div_w[echp_pkg::DIV_STEPS].vld;
      sq_w[0].ins = div_w[echp_pkg::DIV_STEPS].ins;
      sq_w[0].v   = div_w[echp_pkg::DIV_STEPS].eq ? 33'h1_0000_0000
                                                  : div_w[echp_pkg::DIV_STEPS].q;
      sq_w[0].res = 34'd0;
   end

   for (genvar g = 0; g < int'(echp_pkg::SQRT_STEPS); g++) begin : g_sqrt
      echp_sqrt_cell #(.SHIFT(2 * (int'(echp_pkg::SQRT_STEPS) - 1 - g))) u_cell (
         .clock  (clock),
         .reset  (reset),
         .word_i (sq_w[g]),
         .word_o (sq_w[g + 1])
      );
   end

   // table index, weight lookup, shading
   logic [16:0]    d16;
   logic [16+DW:0] kprod;
   logic [16+DW:0] kraw;
   logic [KW-1:0]  k_in, k_ff;
   logic           v4_ff, i4_ff, v5_ff, i5_ff, v6_ff, i6_ff, v7_ff;
   logic [15:0]    wt_ff;
   logic [7:0]     dr, dg, db;
   logic [23:0]    pr_ff, pg_ff, pb3_ff;
   echp_pkg::rsp_type rsp_ff, rsp_in;

   always_comb begin
      d16   = sq_w[echp_pkg::SQRT_STEPS].res[16:0];
      kprod = (17+DW)'(d16) * (17+DW)'(WEIGHT_TABLE_DEPTH);
      kraw  = kprod >> 16;
      if (kraw > (17+DW)'(WEIGHT_TABLE_DEPTH)) k_in = KW'(WEIGHT_TABLE_DEPTH);
      else k_in = kraw[KW-1:0];
      dr = fill_ff[23:16] - base_ff[23:16];
      dg = fill_ff[15:8] - base_ff[15:8];
      db = fill_ff[7:0] - base_ff[7:0];
      rsp_in.inside_res = i6_ff;
      rsp_in.red   = i6_ff ? pr_ff[22:15] + base_ff[23:16] : 8'd0;
      rsp_in.green = i6_ff ? pg_ff[22:15] + base_ff[15:8] : 8'd0;
      rsp_in.blue  = i6_ff ? pb3_ff[22:15] + base_ff[7:0] : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         v4_ff <= sq_w[echp_pkg::SQRT_STEPS].vld;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
      i4_ff  <= sq_w[echp_pkg::SQRT_STEPS].ins;
      k_ff   <= k_in;
      i5_ff  <= i4_ff;
      wt_ff  <= wtab[k_ff];
      i6_ff  <= i5_ff;
      pr_ff  <= wt_ff * dr;
      pg_ff  <= wt_ff * dg;
      pb3_ff <= wt_ff * db;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = v7_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("accepted word did not come out after the pipeline latency");
   a_dark_outside: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.inside_res) |->
      (rsp_data.red == 8'd0 && rsp_data.green == 8'd0 && rsp_data.blue == 8'd0))
      else $error("colour not zero for pixel outside the halo");
   a_no_spurious: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe straight after reset");
   a_small_image: assert property (@(posedge clock) disable iff (reset)
      (start && width_ff < 11'd2) |=> !i1_ff)
      else $error("small image pixel marked inside");
`endif
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Testbench for the elliptic cosine halo pixel unit: directed table, then random pixels per setting
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

   localparam int unsigned DEPTH     = 1024;
   localparam int unsigned LATENCY   = 56;
   localparam int unsigned WDOG_MAX  = 5000;
   localparam int unsigned PHASES    = 10;
   localparam int unsigned PER_PHASE = 125;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   echp_pkg::req_type req_data;
   logic              rsp_valid;
   echp_pkg::rsp_type rsp_data;
   logic              csr_we;
   logic [1:0]        csr_index;
   logic [23:0]       csr_wdata;

   elliptic_cosine_halo_pixel_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // shadow of the block's registers
   logic [10:0]       halo_w, halo_h;
   logic [23:0]       fill_rgb, base_rgb;
   logic [15:0]       weight_lut [0:DEPTH];
   echp_pkg::rsp_type pixel_q[$];
   int                errors;
   int                sender_idle_pct;
   int unsigned       quiet_cycles;

   // (1 + cos(3.14*k/DEPTH)) / 2 in Q1.15 from a Q28 Taylor series
   function automatic logic [15:0] cosine_weight(input longint unsigned k);
      longint unsigned x, x2, t, plus, minus, acc, r;
      x     = ((k * 64'd314) << 28) / (64'd100 * DEPTH);
      x2    = (x * x) >> 28;
      t     = 64'd1 << 28;
      plus  = 64'd2 << 28;
      minus = 0;
      for (int n = 1; n <= 14; n++) begin
         t = ((t * x2) >> 28) / longint'((2 * n - 1) * (2 * n));
         if (n[0]) minus += t;
         else plus += t;
      end
      acc = (plus > minus) ? plus - minus : 64'd0;
      r   = (acc + 64'd8192) >> 14;
      if (r > 64'd32768) r = 64'd32768;
      return r[15:0];
   endfunction

   function automatic logic [7:0] blend(input logic [7:0] f, input logic [7:0] b,
                                        input logic [15:0] wt);
      logic [7:0]  diff;
      logic [31:0] prod;
      diff = f - b;
      prod = wt * diff;
      return prod[22:15] + b;
   endfunction

   function automatic echp_pkg::rsp_type halo_pixel(input echp_pkg::req_type p);
      echp_pkg::rsp_type o;
      longint unsigned cx, cy, dx, dy, q, root, cand, k;
      logic [127:0] dist2, lim2;
      logic [15:0] wt;
      o = '0;
      if (halo_w < 2 || halo_h < 2 || p.column >= halo_w || p.row >= halo_h) return o;
      cx = halo_w >> 1;
      cy = halo_h >> 1;
      dx = (p.column >= cx) ? p.column - cx : cx - p.column;
      dy = (p.row >= cy) ? p.row - cy : cy - p.row;
      lim2  = (cx * cy) * (cx * cy);
      dist2 = dx * dx * cy * cy + dy * dy * cx * cx;
      if (dist2 > lim2) return o;
      q = longint'((dist2 << 32) / lim2);
      root = 0;
      for (int b = 16; b >= 0; b--) begin
         cand = root | (64'd1 << b);
         if (cand * cand <= q) root = cand;
      end
      k = (root * DEPTH) >> 16;
      if (k > DEPTH) k = DEPTH;
      wt = weight_lut[k];
      o.inside_res = 1'b1;
      o.red   = blend(fill_rgb[23:16], base_rgb[23:16], wt);
      o.green = blend(fill_rgb[15:8], base_rgb[15:8], wt);
      o.blue  = blend(fill_rgb[7:0], base_rgb[7:0], wt);
      return o;
   endfunction

   task automatic csr_write(input echp_pkg::csr_index_type idx, input logic [23:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         echp_pkg::CSR_WIDTH:  halo_w = val[10:0];
         echp_pkg::CSR_HEIGHT: halo_h = val[10:0];
         echp_pkg::CSR_FILL:   fill_rgb = val;
         default:              base_rgb = val;
      endcase
   endtask

   // offer one word; hold start until it is taken
   task automatic send_pixel(input echp_pkg::req_type p, input bit known,
                             input echp_pkg::rsp_type want);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= p;
      @(posedge clock);
      while (busy) @(posedge clock);
      pixel_q.push_back(known ? want : halo_pixel(p));
   endtask

   task automatic drain;
      start <= 1'b0;
      wait (pixel_q.size() == 0);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   // checker and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WDOG_MAX) begin
            $display("elliptic_cosine_halo_pixel_unit regression: fail");
            $finish;
         end
         if (rsp_valid) begin
            if (pixel_q.size() == 0) begin
               $display("%0t: unexpected pixel %h", $time, rsp_data);
               errors++;
            end else begin
               if (rsp_data.inside_res !== pixel_q[0].inside_res ||
                   rsp_data.red !== pixel_q[0].red || rsp_data.green !== pixel_q[0].green ||
                   rsp_data.blue !== pixel_q[0].blue) begin
                  $display("%0t: pixel mismatch expected %h actual %h",
                           $time, pixel_q[0], rsp_data);
                  errors++;
               end
               void'(pixel_q.pop_front());
            end
         end
      end
   end

   typedef struct {
      logic [9:0]        col;
      logic [9:0]        row;
      bit                known;
      echp_pkg::rsp_type want;
   } pixel_row_type;

   pixel_row_type pixel_table [12] = '{
      '{10'd32, 10'd16, 1'b1, echp_pkg::rsp_type'({1'b1, 24'hFF8040})},   // centre gives fill
      '{10'd0, 10'd16, 1'b0, '0},                               // on the rim
      '{10'd63, 10'd16, 1'b0, '0},
      '{10'd32, 10'd0, 1'b0, '0},
      '{10'd32, 10'd31, 1'b0, '0},
      '{10'd0, 10'd0, 1'b1, '0},                                // corner outside ellipse
      '{10'd64, 10'd16, 1'b1, '0},                              // past the right edge
      '{10'd32, 10'd32, 1'b1, '0},                              // past the bottom
      '{10'd1023, 10'd1023, 1'b1, '0},
      '{10'd40, 10'd20, 1'b0, '0},
      '{10'd20, 10'd10, 1'b0, '0},
      '{10'd48, 10'd8, 1'b0, '0}
   };

   int unsigned phase_w [PHASES] = '{64, 1024, 1, 50, 0, 1024, 2, 3, 0, 0};
   int unsigned phase_h [PHASES] = '{32, 1024, 50, 1, 0, 2, 1024, 3, 0, 0};

   initial begin
      echp_pkg::req_type p;
      int unsigned w, h;
      errors       = 0;
      quiet_cycles = 0;
      sender_idle_pct = 0;
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = echp_pkg::CSR_WIDTH;
      csr_wdata = '0;
      halo_w = 11'd64; halo_h = 11'd32; fill_rgb = '0; base_rgb = '0;
      for (int k = 0; k <= DEPTH; k++) weight_lut[k] = cosine_weight(k);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_write(echp_pkg::CSR_FILL, 24'hFF8040);
      csr_write(echp_pkg::CSR_BASE, 24'h000000);
      foreach (pixel_table[i]) begin
         p.column = pixel_table[i].col;
         p.row    = pixel_table[i].row;
         send_pixel(p, pixel_table[i].known, pixel_table[i].want);
      end
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         w = (ph >= 8) ? $urandom_range(2, 300) : phase_w[ph];
         h = (ph >= 8) ? $urandom_range(2, 300) : phase_h[ph];
         csr_write(echp_pkg::CSR_WIDTH, 24'(w));
         csr_write(echp_pkg::CSR_HEIGHT, 24'(h));
         case (ph % 3)
            0: begin
               csr_write(echp_pkg::CSR_FILL, 24'hFFFFFF);
               csr_write(echp_pkg::CSR_BASE, 24'h000000);
            end
            1: begin
               csr_write(echp_pkg::CSR_FILL, 24'h000000);
               csr_write(echp_pkg::CSR_BASE, 24'hFFFFFF);
            end
            default: begin
               csr_write(echp_pkg::CSR_FILL, 24'($urandom_range(24'hFFFFFF)));
               csr_write(echp_pkg::CSR_BASE, 24'($urandom_range(24'hFFFFFF)));
            end
         endcase
         case (ph % 4)
            1: sender_idle_pct = 64;
            3: sender_idle_pct = 14;
            default: sender_idle_pct = 0;
         endcase
         for (int n = 0; n < PER_PHASE; n++) begin
            // mostly pixels within the image, the rest anywhere
            if ($urandom_range(9) < 2 || w == 0 || h == 0) begin
               p.column = 10'($urandom_range(1023));
               p.row    = 10'($urandom_range(1023));
            end else begin
               p.column = 10'($urandom_range((w > 1024 ? 1024 : w) - 1));
               p.row    = 10'($urandom_range((h > 1024 ? 1024 : h) - 1));
            end
            send_pixel(p, 1'b0, '0);
         end
         drain();
      end

      if (errors == 0) $display("elliptic_cosine_halo_pixel_unit regression: pass");
      else $display("elliptic_cosine_halo_pixel_unit regression: fail");
      $finish;
   end
endmodule
`default_nettype wire
